/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* hw/rtl/bls_pkg.sv */
// shared types and constants for the bresenham line stepper
// no dependencies
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;

    // request codes carried by req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [COORD_BITS-1:0] steps_t;

    // complete state of the line being stepped
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        err_t   err_term;
        err_t   diag_inc;
        err_t   straight_inc;
        steps_t steps_left;
        logic   x_step_neg;
        logic   y_step_neg;
        logic   x_is_major;
        logic   line_busy;
    } line_state_t;

endpackage

/* hw/rtl/bls_setup.sv */
// line setup: deltas, step signs, major axis and error increments
// depends on bls_pkg
module bls_setup
    import bls_pkg::*;
(
    input  coord_t      start_x,
    input  coord_t      start_y,
    input  coord_t      end_x,
    input  coord_t      end_y,
    output line_state_t line_init
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] dx_abs;
    logic        [COORD_BITS:0] dy_abs;
    steps_t                     adx;
    steps_t                     ady;
    steps_t                     dmaj;
    steps_t                     dmin;
    logic                       x_major;
    err_t                       dmin_x2;
    err_t                       dmaj_x2;

    // signed deltas, one bit wider than a coordinate
    assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};

    // absolute deltas always fit in a coordinate width unsigned
    assign dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    assign adx    = dx_abs[COORD_BITS-1:0];
    assign ady    = dy_abs[COORD_BITS-1:0];

    // y wins a tie
    assign x_major = adx > ady;
    assign dmaj    = x_major ? adx : ady;
    assign dmin    = x_major ? ady : adx;

    assign dmin_x2 = {1'b0, dmin, 1'b0};
    assign dmaj_x2 = {1'b0, dmaj, 1'b0};

    // initial line state, first pixel is the start point
    always_comb
    begin
        line_init.cur_x        = start_x;
        line_init.cur_y        = start_y;
        line_init.err_term     = dmin_x2 - {2'b00, dmaj};
        line_init.diag_inc     = dmin_x2 - dmaj_x2;
        line_init.straight_inc = dmin_x2;
        line_init.steps_left   = dmaj;
        line_init.x_step_neg   = dx[COORD_BITS];
        line_init.y_step_neg   = dy[COORD_BITS];
        line_init.x_is_major   = x_major;
        line_init.line_busy    = (dmaj != '0);
    end

endmodule

/* hw/rtl/bls_step.sv */
// one bresenham step: major axis move, conditional minor move, error update
// depends on bls_pkg
module bls_step
    import bls_pkg::*;
(
    input  line_state_t line_cur,
    output line_state_t line_adv
);

    logic   move_minor;
    logic   finish;
    coord_t step_x;
    coord_t step_y;
    logic   move_x;
    logic   move_y;

    // minor axis moves when the error term is non-negative
    assign move_minor = ~line_cur.err_term[ERR_BITS-1];

    // +1 or -1 in coordinate width
    assign step_x = {{(COORD_BITS-1){line_cur.x_step_neg}}, 1'b1};
    assign step_y = {{(COORD_BITS-1){line_cur.y_step_neg}}, 1'b1};

    assign move_x = line_cur.x_is_major | move_minor;
    assign move_y = ~line_cur.x_is_major | move_minor;

    // this step reaches the far endpoint
    assign finish = (line_cur.steps_left <= steps_t'(1));

    always_comb
    begin
        line_adv              = line_cur;
        line_adv.err_term     = line_cur.err_term +
                                (move_minor ? line_cur.diag_inc : line_cur.straight_inc);
        line_adv.cur_x        = move_x ? (line_cur.cur_x + step_x) : line_cur.cur_x;
        line_adv.cur_y        = move_y ? (line_cur.cur_y + step_y) : line_cur.cur_y;
        line_adv.steps_left   = finish ? '0 : (line_cur.steps_left - steps_t'(1));
        line_adv.line_busy    = ~finish;
    end

endmodule

/* hw/rtl/bresenham_line_stepper_top.sv */
// Bresenham line stepper, one transaction per clock while not stalled. A start
// transaction (req_type 0) sets up the line and returns the start point; each step
// transaction (req_type 1) returns the next pixel, with last_pixel on the one that
// reaches the far endpoint. A step while no line is active returns nothing. On
// acceptance the line state and the result register load at the same edge, so a
// pixel appears in the next cycle and a new transaction can be taken every cycle
// unless stalled. The rate is set by the error add and compare on the registered
// line state. in_stall is raised only while a result waits and out_stall is high.
// depends on bls_pkg, bls_setup, bls_step and assert_macros.svh
`include "assert_macros.svh"

module bresenham_line_stepper_top
    import bls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   req_type,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output logic   out_valid,
    input  logic   out_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output logic   last_pixel
);

    line_state_t line_reg;
    line_state_t line_next;
    line_state_t line_init;
    line_state_t line_adv;
    logic        out_valid_reg;
    logic        out_valid_next;
    coord_t      pix_x_reg;
    coord_t      pix_x_next;
    coord_t      pix_y_reg;
    coord_t      pix_y_next;
    logic        last_reg;
    logic        last_next;
    logic        in_accept;
    logic        start_accept;
    logic        produce;

    bls_setup u_setup (
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .line_init (line_init)
    );

    bls_step u_step (
        .line_cur (line_reg),
        .line_adv (line_adv)
    );

    // hold off input only while a result waits to be taken
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // start transaction taken this cycle
    assign start_accept = in_accept & (req_type == REQ_START);

    // next line state and result
    always_comb
    begin
        line_next  = line_reg;
        produce    = 1'b0;
        if (in_accept)
        begin
            if (req_type == REQ_START)
            begin
                line_next = line_init;
                produce   = 1'b1;
            end
            else if (line_reg.line_busy)
            begin
                line_next = line_adv;
                produce   = 1'b1;
            end
        end
        pix_x_next = produce ? line_next.cur_x : pix_x_reg;
        pix_y_next = produce ? line_next.cur_y : pix_y_reg;
        last_next  = produce ? ~line_next.line_busy : last_reg;
        if (produce)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // line state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        pix_x_reg <= pix_x_next;
        pix_y_reg <= pix_y_next;
        last_reg  <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

    // checks
    `ASSERT_PROP(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid_reg)
    `ASSERT_PROP(a_start_x, clk, rst_n, start_accept |=> (out_valid && pixel_x == $past(start_x)))
    `ASSERT_PROP(a_start_y, clk, rst_n, start_accept |=> (out_valid && pixel_y == $past(start_y)))
    `ASSERT_NEVER(a_busy_has_steps, clk, rst_n, line_reg.line_busy && line_reg.steps_left == '0)
    `ASSERT_PROP(a_last_means_idle, clk, rst_n, (out_valid && last_pixel) |-> !line_reg.line_busy)

endmodule

/* tb/bresenham_line_stepper_top_tb.sv */
// self-checking testbench for bresenham_line_stepper_top: directed and random line requests
// a built-in line stepper predicts each pixel; depends on bls_pkg and the rtl top level
module bresenham_line_stepper_top_tb;
    import bls_pkg::*;

    localparam int CMAX       = 2**(COORD_BITS-1) - 1;
    localparam int CMIN       = -CMAX - 1;
    localparam int N_ITEMS    = 1850;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 8;

    // one request as queued for the driver
    typedef struct {
        logic   kind;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     gap;
    } line_req_t;

    // one pixel as the block should return it
    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    logic   in_stall;
    logic   req_type   = REQ_START;
    coord_t start_x    = '0;
    coord_t start_y    = '0;
    coord_t end_x      = '0;
    coord_t end_y      = '0;
    logic   out_valid;
    logic   out_stall  = 1'b0;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    line_req_t pending_reqs[$];
    pixel_t    expected_pixels[$];

    // predicted line state
    coord_t ln_x;
    coord_t ln_y;
    err_t   ln_err;
    err_t   ln_diag;
    err_t   ln_straight;
    steps_t ln_left;
    logic   ln_xneg;
    logic   ln_yneg;
    logic   ln_xmajor;
    logic   ln_active = 1'b0;

    int n_items     = 0;
    int n_accepted  = 0;
    int n_starts    = 0;
    int n_pixels    = 0;
    int n_line_ends = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int in_gap      = 0;
    int stall_left  = 0;
    int out_cycles  = 0;
    bit in_calm     = 1'b0;
    bit out_calm    = 1'b0;
    bit stuck       = 1'b0;

    bresenham_line_stepper_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(0, 2**COORD_BITS - 1));
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v > CMAX)
            return coord_t'(CMAX);
        if (v < CMIN)
            return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic add_req(logic kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        line_req_t r;
        if (n_items % 150 == 0)
            in_calm = ($urandom_range(0, 2) == 0);
        r.kind = kind;
        r.sx   = sx;
        r.sy   = sy;
        r.ex   = ex;
        r.ey   = ey;
        r.gap  = pick_gap(in_calm);
        pending_reqs.push_back(r);
        n_items++;
    endtask

    // step payload fields are ignored, so fill them with noise
    task automatic add_step();
        add_req(REQ_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic add_line(int sx, int sy, int ex, int ey, int steps);
        add_req(REQ_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
        repeat (steps) add_step();
    endtask

    // predictor: advance the line model by one accepted transaction
    task automatic advance_line(logic kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int     dx;
        int     dy;
        int     dmaj;
        int     dmin;
        logic   move_minor;
        pixel_t p;
        if (kind == REQ_START)
        begin
            dx        = int'(ex) - int'(sx);
            dy        = int'(ey) - int'(sy);
            ln_xneg   = (dx < 0);
            ln_yneg   = (dy < 0);
            dx        = abs_int(dx);
            dy        = abs_int(dy);
            ln_xmajor = (dx > dy);
            dmaj      = ln_xmajor ? dx : dy;
            dmin      = ln_xmajor ? dy : dx;
            ln_x        = sx;
            ln_y        = sy;
            ln_err      = err_t'(2 * dmin - dmaj);
            ln_diag     = err_t'(2 * (dmin - dmaj));
            ln_straight = err_t'(2 * dmin);
            ln_left     = steps_t'(dmaj);
            ln_active   = (dmaj != 0);
        end
        else
        begin
            // a step with no line in progress produces nothing
            if (!ln_active)
                return;
            move_minor = (ln_err >= 0);
            ln_err = move_minor ? ln_err + ln_diag : ln_err + ln_straight;
            if (ln_xmajor || move_minor)
                ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
            if (!ln_xmajor || move_minor)
                ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
            ln_left = ln_left - 1'b1;
            if (ln_left == 0)
                ln_active = 1'b0;
        end
        p.x    = ln_x;
        p.y    = ln_y;
        p.last = !ln_active;
        expected_pixels.push_back(p);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= 30)
            $display("mismatch on pixel %0d: %s got %0d expected %0d", n_pixels, what, got, want);
    endtask

    // driver: present queued requests, hold them while stalled
    always @(posedge clk)
    begin
        line_req_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_line(req_type, start_x, start_y, end_x, end_y);
                n_accepted++;
                if (req_type == REQ_START)
                    n_starts++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    r = pending_reqs.pop_front();
                    in_gap = r.gap;
                    in_valid <= 1'b1;
                    req_type <= r.kind;
                    start_x  <= r.sx;
                    start_y  <= r.sy;
                    end_x    <= r.ex;
                    end_y    <= r.ey;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted pixel and drive random stalls
    always @(posedge clk)
    begin
        pixel_t want;
        int     len;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_pixels++;
                if (last_pixel === 1'b1)
                    n_line_ends++;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("pixel_x with no pixel expected", pixel_x, 0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.x)
                        report_mismatch("pixel_x", pixel_x, want.x);
                    if (pixel_y !== want.y)
                        report_mismatch("pixel_y", pixel_y, want.y);
                    if (last_pixel !== want.last)
                        report_mismatch("last_pixel", last_pixel, want.last);
                end
            end
            // alternate between stall-free stretches and random stalls
            out_cycles++;
            if (out_cycles % 256 == 0)
                out_calm = ($urandom_range(0, 2) == 0);
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                len = pick_gap(out_calm);
                stall_left = (len != 0) ? len - 1 : 0;
                out_stall <= (len != 0);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n && !stuck)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                    stuck = 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int kind;
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int d;
        int dmaj;

        // directed: idle step, single points, corners, start while busy, axis lines, tie
        add_step();
        add_line(0, 0, 0, 0, 0);
        add_step();
        add_line(CMIN, CMIN, CMAX, CMAX, 1);
        add_line(CMAX, CMIN, CMIN, CMAX, 1);
        add_line(CMAX, CMAX, CMAX, CMAX, 0);
        add_line(CMIN, 5, CMIN + 3, 5, 4);
        add_line(3, CMAX, 3, CMAX - 2, 2);
        add_line(10, -4, 5, -6, 5);
        add_line(0, 0, 2, -2, 2);

        // random: mostly complete lines, some cut short, some stray steps
        while (n_items < N_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                d = $urandom_range(0, 99);
                if (d < 85)
                    span = $urandom_range(0, 12);
                else if (d < 98)
                    span = $urandom_range(13, 80);
                else
                    span = $urandom_range(200, 400);
                x0 = int'(rand_coord());
                y0 = int'(rand_coord());
                d  = $urandom_range(0, 2 * span);
                x1 = int'(clamp_coord(x0 + d - span));
                d  = $urandom_range(0, 2 * span);
                y1 = int'(clamp_coord(y0 + d - span));
                dmaj = abs_int(x1 - x0);
                if (abs_int(y1 - y0) > dmaj)
                    dmaj = abs_int(y1 - y0);
                if ($urandom_range(0, 99) < 15)
                    dmaj += $urandom_range(1, 2);
                add_line(x0, y0, x1, y1, dmaj);
            end
            else if (kind < 88)
            begin
                add_req(REQ_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
                repeat ($urandom_range(0, 6)) add_step();
            end
            else
            begin
                repeat ($urandom_range(1, 3)) add_step();
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!stuck && (n_accepted < n_items || expected_pixels.size() != 0))
            @(posedge clk);

        if (stuck)
        begin
            $display("timeout: %0d idle cycles, %0d pixels still expected",
                     IDLE_LIMIT, expected_pixels.size());
            $display("FAIL bresenham_line_stepper_top");
        end
        else
        begin
            repeat (DRAIN) @(posedge clk);
            $display("ran %0d requests (%0d line starts) and checked %0d pixels",
                     n_accepted, n_starts, n_pixels);
            $display("%0d lines reached their last pixel, %0d mismatches",
                     n_line_ends, n_errors);
            if (n_errors == 0 && expected_pixels.size() == 0)
                $display("PASS bresenham_line_stepper_top");
            else
                $display("FAIL bresenham_line_stepper_top");
        end
        $finish;
    end

endmodule
